// File: hdl/tsps_pkg.sv
// Shared types and codes for the timed setpoint profile sequencer.
package tsps_pkg;

  typedef enum logic [2:0] {
    FN_LOAD   = 3'd0,
    FN_START  = 3'd1,
    FN_PAUSE  = 3'd2,
    FN_RESUME = 3'd3,
    FN_STOP   = 3'd4,
    FN_TICK   = 3'd5
  } func_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_IGNORED = 2'd1;
  localparam status_t ST_REJECT  = 2'd2;
  localparam status_t ST_BLOCKED = 2'd3;

  typedef logic [1:0] pid_cmd_t;
  localparam pid_cmd_t PID_NONE  = 2'd0;
  localparam pid_cmd_t PID_START = 2'd1;
  localparam pid_cmd_t PID_STOP  = 2'd2;

  typedef logic [1:0] abort_t;
  localparam abort_t ABORT_NONE     = 2'd0;
  localparam abort_t ABORT_PANIC    = 2'd1;
  localparam abort_t ABORT_FAILSAFE = 2'd2;

  // Register index of profile_length on the configuration port.
  localparam logic REG_PROFILE_LENGTH = 1'b0;

  // Table write request from the sequencer core.
  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [31:0] step_time;
    logic [15:0] step_target;
  } tbl_wr_t;

endpackage

// File: hdl/tsps_table.sv
// Step table: start time and target per step, one read address per field.
module tsps_table
  import tsps_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  tbl_wr_t     wr,
  input  logic [8:0]  time_addr,
  input  logic [8:0]  tgt_addr,
  output logic [31:0] time_rd,
  output logic [15:0] tgt_rd
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [8:0] DEPTH_W = 9'(DEPTH);

  logic [31:0] time_tbl [DEPTH];
  logic [15:0] tgt_tbl  [DEPTH];
  logic [8:0]  wr_wide;

  assign wr_wide = {5'd0, wr.addr};

  always_ff @(posedge clk) begin
    if (wr.we && (wr_wide < DEPTH_W)) begin
      time_tbl[wr_wide[IW-1:0]] <= wr.step_time;
      tgt_tbl[wr_wide[IW-1:0]]  <= wr.step_target;
    end
  end

  // Entries past the table end read as zero.
  assign time_rd = (time_addr < DEPTH_W) ? time_tbl[time_addr[IW-1:0]] : 32'd0;
  assign tgt_rd  = (tgt_addr < DEPTH_W) ? tgt_tbl[tgt_addr[IW-1:0]] : 16'd0;

endmodule

// File: hdl/timed_setpoint_profile_sequencer.sv
// Top level of the timed setpoint profile sequencer.
//
//   Channel   Direction  Handshake                 Carries
//   in_*      input      in_valid / in_stall       one event per transfer
//   out_*     output     out_valid / out_stall     one result per event
//   cfg APB   input      psel penable pwrite       profile_length at byte 0
//
// Every event is decoded in the cycle it is accepted and its result is held in
// the output register on the next cycle, so one event per cycle is sustained.
// The limit is the single compare and subtract path from the event to the
// output register. A stalled result holds the input side only while the output
// register is full and not taken. Reset (rst_n low, synchronous) clears the run
// state and profile_length; the step table holds garbage until loaded.
module timed_setpoint_profile_sequencer
  import tsps_pkg::*;
#(
  parameter int MAX_PROFILE_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Event channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_now_ms,
  input  logic        in_panic,
  input  logic        in_failsafe,
  input  logic [3:0]  in_step_index,
  input  logic [31:0] in_step_time,
  input  logic signed [15:0] in_step_target,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_run_active,
  output logic        out_run_paused,
  output logic [3:0]  out_step_now,
  output logic        out_set_target,
  output logic signed [15:0] out_target_temp,
  output logic [1:0]  out_pid_cmd,
  output logic        out_outputs_off,
  output logic [1:0]  out_abort_cause,
  output logic [31:0] out_remaining_ms,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Only the first sixteen table entries can be addressed by a load, so the
  // table never needs to be deeper than that.
  localparam int TBL_DEPTH = (MAX_PROFILE_STEPS < 16) ? MAX_PROFILE_STEPS : 16;
  localparam logic [8:0] MAX_W = 9'(MAX_PROFILE_STEPS);

  // Run state.
  logic        running_r, running_nxt;
  logic        held_r, held_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] pause_r, pause_nxt;
  logic [31:0] ptot_r, ptot_nxt;
  logic [4:0]  len_r;
  // Cached table values: time of the last step in use, time of the step after
  // the current one, and the current step's target. They keep the table down
  // to one read address per field.
  logic [31:0] last_time_r, last_time_nxt;
  logic [31:0] next_time_r, next_time_nxt;
  logic [15:0] cur_tgt_r, cur_tgt_nxt;

  // Result register.
  logic        o_valid_r;
  status_t     o_status_r, status_nxt;
  logic        o_set_r, set_nxt;
  logic [15:0] o_tgt_r, tgt_nxt;
  pid_cmd_t    o_pid_r, pid_nxt;
  logic        o_off_r, off_nxt;
  abort_t      o_cause_r, cause_nxt;
  logic [31:0] o_rem_r, rem_nxt;

  logic        acc;
  logic        cfg_wr;
  logic        safety;
  logic [4:0]  len_wr;
  logic [4:0]  step_p1;
  logic [31:0] el_now;
  logic [31:0] el_after;
  logic [15:0] issued;
  logic [8:0]  time_addr;
  logic [8:0]  tgt_addr;
  logic [31:0] time_rd;
  logic [15:0] tgt_rd;
  tbl_wr_t     tbl_wr;

  assign acc      = in_valid && !in_stall;
  assign in_stall = o_valid_r && out_stall;
  assign safety   = in_panic || in_failsafe;
  assign step_p1  = {1'b0, step_r} + 5'd1;
  assign el_now   = in_now_ms - start_r - ptot_r;

  // APB: always ready, one register at byte address zero. An out of range
  // length clears the profile.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PROFILE_LENGTH);
  assign len_wr = ({4'd0, pwdata[4:0]} > MAX_W) ? 5'd0 : pwdata[4:0];
  assign prdata = (paddr[2] == REG_PROFILE_LENGTH) ? {27'd0, len_r} : 32'd0;

  // Table read addresses. The user must not write the configuration with an
  // event (unchecked); a write borrows the time port for the new last step time.
  always_comb begin
    if (cfg_wr) begin
      time_addr = {4'd0, len_wr - 5'd1};
    end else if (func_t'(in_func) == FN_START) begin
      time_addr = 9'd1;
    end else begin
      time_addr = {4'd0, step_p1} + 9'd1;
    end
    tgt_addr = (func_t'(in_func) == FN_START) ? 9'd0 : {4'd0, step_p1};
  end

  tsps_table #(
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk      (clk),
    .wr       (tbl_wr),
    .time_addr(time_addr),
    .tgt_addr (tgt_addr),
    .time_rd  (time_rd),
    .tgt_rd   (tgt_rd)
  );

  // Event decode.
  always_comb begin
    running_nxt   = running_r;
    held_nxt      = held_r;
    step_nxt      = step_r;
    start_nxt     = start_r;
    pause_nxt     = pause_r;
    ptot_nxt      = ptot_r;
    last_time_nxt = last_time_r;
    next_time_nxt = next_time_r;
    cur_tgt_nxt   = cur_tgt_r;
    status_nxt    = ST_DONE;
    set_nxt       = 1'b0;
    issued        = 16'd0;
    pid_nxt       = PID_NONE;
    off_nxt       = 1'b0;
    cause_nxt     = ABORT_NONE;
    tbl_wr.we          = 1'b0;
    tbl_wr.addr        = in_step_index;
    tbl_wr.step_time   = in_step_time;
    tbl_wr.step_target = in_step_target;

    case (func_t'(in_func))
      FN_LOAD: begin
        if (running_r || held_r) begin
          status_nxt = ST_REJECT;
        end else if ({5'd0, in_step_index} >= MAX_W) begin
          status_nxt = ST_IGNORED;
        end else begin
          tbl_wr.we = acc;
          if ((len_r != 5'd0) && ({1'b0, in_step_index} == len_r - 5'd1)) begin
            last_time_nxt = in_step_time;
          end
        end
      end
      FN_START: begin
        if (len_r == 5'd0) begin
          status_nxt = ST_REJECT;
        end else if (safety) begin
          status_nxt = ST_BLOCKED;
        end else begin
          running_nxt   = 1'b1;
          held_nxt      = 1'b0;
          step_nxt      = 4'd0;
          start_nxt     = in_now_ms;
          ptot_nxt      = 32'd0;
          set_nxt       = 1'b1;
          issued        = tgt_rd;
          cur_tgt_nxt   = tgt_rd;
          next_time_nxt = time_rd;
          pid_nxt       = PID_START;
        end
      end
      FN_PAUSE: begin
        if (!running_r || held_r) begin
          status_nxt = ST_IGNORED;
        end else begin
          held_nxt  = 1'b1;
          pause_nxt = in_now_ms;
          pid_nxt   = PID_STOP;
        end
      end
      FN_RESUME: begin
        if (!held_r) begin
          status_nxt = ST_IGNORED;
        end else if (safety) begin
          status_nxt = ST_BLOCKED;
        end else begin
          held_nxt = 1'b0;
          ptot_nxt = ptot_r + (in_now_ms - pause_r);
          pid_nxt  = PID_START;
        end
      end
      FN_STOP: begin
        running_nxt = 1'b0;
        held_nxt    = 1'b0;
        step_nxt    = 4'd0;
        pid_nxt     = PID_STOP;
      end
      FN_TICK: begin
        if (safety) begin
          // Abort is reported only when a run was actually in progress.
          if (running_r || held_r) begin
            off_nxt   = 1'b1;
            cause_nxt = in_panic ? ABORT_PANIC : ABORT_FAILSAFE;
          end
          running_nxt = 1'b0;
          held_nxt    = 1'b0;
          step_nxt    = 4'd0;
        end else if (!running_r || held_r) begin
          status_nxt = ST_IGNORED;
        end else if (len_r == 5'd0) begin
          running_nxt = 1'b0;
          step_nxt    = 4'd0;
          pid_nxt     = PID_STOP;
        end else begin
          if ((step_p1 < len_r) && (el_now >= next_time_r)) begin
            step_nxt      = step_p1[3:0];
            set_nxt       = 1'b1;
            issued        = tgt_rd;
            cur_tgt_nxt   = tgt_rd;
            next_time_nxt = time_rd;
          end
          if (el_now > last_time_r) begin
            running_nxt = 1'b0;
            held_nxt    = 1'b0;
            step_nxt    = 4'd0;
            pid_nxt     = PID_STOP;
          end
        end
      end
      default: begin
        status_nxt = ST_IGNORED;
      end
    endcase

    if (set_nxt) begin
      tgt_nxt = issued;
    end else if (running_nxt && ({1'b0, step_nxt} < len_r)) begin
      tgt_nxt = cur_tgt_nxt;
    end else begin
      tgt_nxt = 16'd0;
    end

    // Remaining time is measured with the state left by this event.
    el_after = in_now_ms - start_nxt - ptot_nxt;
    if (running_nxt && (len_r != 5'd0) && (el_after < last_time_r)) begin
      rem_nxt = last_time_r - el_after;
    end else begin
      rem_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      held_r      <= 1'b0;
      step_r      <= 4'd0;
      start_r     <= 32'd0;
      pause_r     <= 32'd0;
      ptot_r      <= 32'd0;
      len_r       <= 5'd0;
      last_time_r <= 32'd0;
      o_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        len_r       <= len_wr;
        last_time_r <= time_rd;
      end else if (acc) begin
        running_r   <= running_nxt;
        held_r      <= held_nxt;
        step_r      <= step_nxt;
        start_r     <= start_nxt;
        pause_r     <= pause_nxt;
        ptot_r      <= ptot_nxt;
        last_time_r <= last_time_nxt;
      end
      if (acc) begin
        o_valid_r <= 1'b1;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // Payload and cached table values need no reset.
  always_ff @(posedge clk) begin
    if (acc) begin
      next_time_r <= next_time_nxt;
      cur_tgt_r   <= cur_tgt_nxt;
      o_status_r  <= status_nxt;
      o_set_r     <= set_nxt;
      o_tgt_r     <= tgt_nxt;
      o_pid_r     <= pid_nxt;
      o_off_r     <= off_nxt;
      o_cause_r   <= cause_nxt;
      o_rem_r     <= rem_nxt;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_status      = o_status_r;
  assign out_run_active  = running_r;
  assign out_run_paused  = held_r;
  assign out_step_now    = step_r;
  assign out_set_target  = o_set_r;
  assign out_target_temp = o_tgt_r;
  assign out_pid_cmd     = o_pid_r;
  assign out_outputs_off = o_off_r;
  assign out_abort_cause = o_cause_r;
  assign out_remaining_ms = o_rem_r;

`ifndef SYNTHESIS
  // A paused run is always a run.
  a_held_running: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> running_r)
    else $error("paused without an active run");

  // A new target never goes into a paused run, and the run stays active
  // unless the same tick that entered the last step also finished it.
  a_set_active: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_set_r) |-> (!held_r && (running_r || (o_pid_r == PID_STOP))))
    else $error("target issued outside an active run");

  // The outputs are forced off exactly when an abort cause is reported.
  a_off_cause: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> (o_off_r == (o_cause_r != ABORT_NONE)))
    else $error("outputs_off and abort_cause disagree");

  // An abort always leaves the block idle at step zero.
  a_abort_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_off_r) |-> (!running_r && (step_r == 4'd0)))
    else $error("run survived an abort");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the timed setpoint profile sequencer.
module tb_top
  import tsps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int EVENT_GOAL = 1650;
  localparam int CALM_AFTER = 1450;
  localparam int REPORT_CAP = 30;

  // Function codes that the package does not name; the block must ignore them.
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;

  // One result of the block, in port order.
  typedef struct packed {
    status_t            status;
    logic               active;
    logic               paused;
    logic [3:0]         step;
    logic               set_target;
    logic signed [15:0] target;
    pid_cmd_t           pid;
    logic               off;
    abort_t             cause;
    logic [31:0]        remaining;
  } profile_result_t;

  localparam profile_result_t NO_RESULT = '0;

  // One event, plus the directed-table extras: a profile_length to write
  // beforehand (negative for none) and an optional hand-typed result.
  typedef struct {
    int                 cfg_len;
    logic [2:0]         func;
    logic [31:0]        now;
    logic               panic;
    logic               failsafe;
    logic [3:0]         sidx;
    logic [31:0]        stime;
    logic signed [15:0] starg;
    bit                 typed;
    profile_result_t    res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_func;
  logic [31:0]        in_now_ms;
  logic               in_panic;
  logic               in_failsafe;
  logic [3:0]         in_step_index;
  logic [31:0]        in_step_time;
  logic signed [15:0] in_step_target;

  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic               out_run_active;
  logic               out_run_paused;
  logic [3:0]         out_step_now;
  logic               out_set_target;
  logic signed [15:0] out_target_temp;
  logic [1:0]         out_pid_cmd;
  logic               out_outputs_off;
  logic [1:0]         out_abort_cause;
  logic [31:0]        out_remaining_ms;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  timed_setpoint_profile_sequencer #(
    .MAX_PROFILE_STEPS(STEPS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_now_ms       (in_now_ms),
    .in_panic        (in_panic),
    .in_failsafe     (in_failsafe),
    .in_step_index   (in_step_index),
    .in_step_time    (in_step_time),
    .in_step_target  (in_step_target),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_run_active  (out_run_active),
    .out_run_paused  (out_run_paused),
    .out_step_now    (out_step_now),
    .out_set_target  (out_set_target),
    .out_target_temp (out_target_temp),
    .out_pid_cmd     (out_pid_cmd),
    .out_outputs_off (out_outputs_off),
    .out_abort_cause (out_abort_cause),
    .out_remaining_ms(out_remaining_ms),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Sequencer state as the testbench believes it to be. The step tables start
  // out unknown, and the stimulus loads every entry before any run reads one.
  logic [4:0]         prof_len = '0;
  bit                 run_on = 0;
  bit                 run_held = 0;
  logic [3:0]         step_reg = '0;
  logic [31:0]        start_ms = '0;
  logic [31:0]        pause_ms = '0;
  logic [31:0]        paused_ms = '0;
  logic [31:0]        step_times [STEPS];
  logic signed [15:0] step_targets [STEPS];

  profile_result_t pending_results [$];
  profile_result_t got_result;
  profile_result_t want_result;
  stim_row_t       plan [$];

  int error_count = 0;
  int event_count = 0;   // accepted events
  int stall_left = 0;
  bit idling_on = 1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the whole run. A correct run needs well under a tenth of it.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= REPORT_CAP) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Works out the result of one accepted event and advances the believed
  // state. Elapsed time is taken modulo 2^32, so a start just below the wrap
  // point behaves exactly like any other start.
  function automatic profile_result_t next_profile_result(stim_row_t r);
    profile_result_t    o;
    logic               safety;
    logic               set_t;
    logic signed [15:0] issued;
    logic [31:0]        el;
    logic [31:0]        last_ms;
    logic [4:0]         nxt;
    o = '0;
    set_t = 1'b0;
    issued = '0;
    safety = r.panic | r.failsafe;
    case (r.func)
      FN_LOAD: begin
        if (run_on || run_held) begin
          o.status = ST_REJECT;
        end else begin
          step_times[r.sidx] = r.stime;
          step_targets[r.sidx] = r.starg;
        end
      end
      FN_START: begin
        if (prof_len == 0) begin
          o.status = ST_REJECT;
        end else if (safety) begin
          o.status = ST_BLOCKED;
        end else begin
          run_on = 1;
          run_held = 0;
          step_reg = '0;
          start_ms = r.now;
          paused_ms = '0;
          set_t = 1'b1;
          issued = step_targets[0];
          o.pid = PID_START;
        end
      end
      FN_PAUSE: begin
        if (!run_on || run_held) begin
          o.status = ST_IGNORED;
        end else begin
          run_held = 1;
          pause_ms = r.now;
          o.pid = PID_STOP;
        end
      end
      FN_RESUME: begin
        if (!run_held) begin
          o.status = ST_IGNORED;
        end else if (safety) begin
          o.status = ST_BLOCKED;
        end else begin
          run_held = 0;
          paused_ms = paused_ms + (r.now - pause_ms);
          o.pid = PID_START;
        end
      end
      FN_STOP: begin
        run_on = 0;
        run_held = 0;
        step_reg = '0;
        o.pid = PID_STOP;
      end
      FN_TICK: begin
        if (safety) begin
          // Only a live run (active or paused) counts as aborted.
          if (run_on || run_held) begin
            o.off = 1'b1;
            o.cause = r.panic ? ABORT_PANIC : ABORT_FAILSAFE;
          end
          run_on = 0;
          run_held = 0;
          step_reg = '0;
        end else if (!run_on || run_held) begin
          o.status = ST_IGNORED;
        end else if (prof_len == 0) begin
          run_on = 0;
          step_reg = '0;
          o.pid = PID_STOP;
        end else begin
          el = r.now - start_ms - paused_ms;
          nxt = {1'b0, step_reg} + 5'd1;
          if (nxt < prof_len && el >= step_times[nxt[3:0]]) begin
            step_reg = nxt[3:0];
            set_t = 1'b1;
            issued = step_targets[nxt[3:0]];
          end
          last_ms = step_times[4'(prof_len - 5'd1)];
          if (el > last_ms) begin
            run_on = 0;
            run_held = 0;
            step_reg = '0;
            o.pid = PID_STOP;
          end
        end
      end
      default: o.status = ST_IGNORED;
    endcase

    o.active = run_on;
    o.paused = run_held;
    o.step = step_reg;
    o.set_target = set_t;
    if (set_t) o.target = issued;
    else if (run_on && step_reg < prof_len) o.target = step_targets[step_reg];

    // Remaining time keeps shrinking during a pause because the pause total
    // is only updated on resume.
    if (run_on && prof_len != 0) begin
      el = r.now - start_ms - paused_ms;
      last_ms = step_times[4'(prof_len - 5'd1)];
      o.remaining = (el >= last_ms) ? 32'd0 : last_ms - el;
    end
    return o;
  endfunction

  // Drives one event. Inputs change on the falling edge only; an optional
  // gap with valid low comes first. The transfer happens at the first rising
  // edge that sees in_stall low.
  task automatic drive_event(stim_row_t r);
    int              gap;
    profile_result_t predicted;
    gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_func = r.func;
    in_now_ms = r.now;
    in_panic = r.panic;
    in_failsafe = r.failsafe;
    in_step_index = r.sidx;
    in_step_time = r.stime;
    in_step_target = r.starg;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = next_profile_result(r);
    event_count++;
    pending_results.push_back(r.typed ? r.res : predicted);
  endtask

  task automatic send_event(logic [2:0] f, logic [31:0] now, bit pan, bit fs,
                            logic [3:0] idx, logic [31:0] st, logic signed [15:0] tg);
    stim_row_t r;
    r.cfg_len = -1;
    r.func = f;
    r.now = now;
    r.panic = pan;
    r.failsafe = fs;
    r.sidx = idx;
    r.stime = st;
    r.starg = tg;
    r.typed = 0;
    r.res = NO_RESULT;
    drive_event(r);
  endtask

  // Drops valid and holds off until every outstanding result has come back.
  // Each event yields exactly one result, so nothing is in flight afterwards.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_transfer(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {REG_PROFILE_LENGTH, 2'b00};
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Writes profile_length with random upper bits, then reads it back. Values
  // above the table size are stored as zero.
  task automatic set_profile_length(logic [4:0] len);
    logic [31:0] rd;
    drain_results();
    apb_transfer(1'b1, ($urandom & ~32'h1F) | 32'(len), rd);
    prof_len = (len > 5'(STEPS)) ? 5'd0 : len;
    apb_transfer(1'b0, 32'd0, rd);
    if (rd !== 32'(prof_len))
      report_mismatch($sformatf("profile_length read %0d want %0d", rd, prof_len));
  endtask

  function automatic profile_result_t idle_result(status_t s, pid_cmd_t p);
    profile_result_t o;
    o = '0;
    o.status = s;
    o.pid = p;
    return o;
  endfunction

  function automatic stim_row_t mk(int cfg, logic [2:0] f, logic [31:0] now, bit pan,
                                   bit fs, logic [3:0] idx, logic [31:0] st,
                                   logic signed [15:0] tg, bit typed,
                                   profile_result_t res);
    stim_row_t r;
    r.cfg_len = cfg;
    r.func = f;
    r.now = now;
    r.panic = pan;
    r.failsafe = fs;
    r.sidx = idx;
    r.stime = st;
    r.starg = tg;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  // A well-formed run: stop, load the steps in use with non-decreasing times,
  // start, then mostly ticks that walk through the steps, with pauses, resumes,
  // restarts, stray commands and the odd safety trip mixed in.
  task automatic run_profile_phase();
    logic [31:0] clock_ms;
    logic [31:0] acc;
    logic [31:0] span;
    int          loads;
    int          pick;
    bit          pan;
    bit          fs;
    clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                            : $urandom;
    send_event(FN_STOP, clock_ms, 0, 0, 4'($urandom), $urandom, 16'($urandom));
    loads = (prof_len == 0) ? $urandom_range(1, 3) : int'(prof_len);
    acc = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(0, 300);
    span = acc;
    for (int i = 0; i < loads; i++) begin
      span = acc;
      send_event(FN_LOAD, $urandom, 0, 0, 4'(i), acc, 16'($urandom));
      // Equal neighbouring times now and then, so two steps fall due at once.
      acc += ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 1500);
    end
    pan = ($urandom_range(0, 9) == 0);
    fs = ($urandom_range(0, 9) == 0);
    send_event(FN_START, clock_ms, pan, fs, 4'($urandom), $urandom, 16'($urandom));
    repeat ($urandom_range(4, 30)) begin
      clock_ms += $urandom_range(0, span / 6 + 40);
      pick = $urandom_range(0, 99);
      pan = 0;
      fs = 0;
      if ($urandom_range(0, 39) == 0 || (pick >= 84 && pick < 93 &&
                                         $urandom_range(0, 9) == 0)) begin
        pan = 1'($urandom_range(0, 1));
        fs = !pan || $urandom_range(0, 1);
      end
      if (pick < 78)
        send_event(FN_TICK, clock_ms, pan, fs, 4'($urandom), $urandom, 16'($urandom));
      else if (pick < 84)
        send_event(FN_PAUSE, clock_ms, pan, fs, 4'($urandom), $urandom, 16'($urandom));
      else if (pick < 90)
        send_event(FN_RESUME, clock_ms, pan, fs, 4'($urandom), $urandom, 16'($urandom));
      else if (pick < 93)
        send_event(FN_START, clock_ms, pan, fs, 4'($urandom), $urandom, 16'($urandom));
      else if (pick < 95)
        send_event(FN_STOP, clock_ms, pan, fs, 4'($urandom), $urandom, 16'($urandom));
      else if (pick < 98)
        send_event(FN_LOAD, clock_ms, pan, fs, 4'($urandom), $urandom, 16'($urandom));
      else
        send_event(pick[0] ? FN_SPARE7 : FN_SPARE6, clock_ms, pan, fs,
                   4'($urandom), $urandom, 16'($urandom));
      // Once the run is over, often move on rather than tick into the void.
      if (!run_on && !run_held && $urandom_range(0, 1) == 1) break;
    end
  endtask

  // Anything goes: every field random, every function code, safety often.
  task automatic run_noise_phase();
    repeat ($urandom_range(8, 25))
      send_event(3'($urandom_range(0, 7)), $urandom, $urandom_range(0, 3) == 0,
                 $urandom_range(0, 3) == 0, 4'($urandom), $urandom, 16'($urandom));
  endtask

  // Result side: stall in random bursts while idling is on.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Every transfer on the result side is checked against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result.status = out_status;
      got_result.active = out_run_active;
      got_result.paused = out_run_paused;
      got_result.step = out_step_now;
      got_result.set_target = out_set_target;
      got_result.target = out_target_temp;
      got_result.pid = out_pid_cmd;
      got_result.off = out_outputs_off;
      got_result.cause = out_abort_cause;
      got_result.remaining = out_remaining_ms;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no event outstanding");
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.status !== want_result.status)
          report_mismatch($sformatf("status %0d want %0d",
                                    got_result.status, want_result.status));
        if (got_result.active !== want_result.active)
          report_mismatch($sformatf("run_active %0d want %0d",
                                    got_result.active, want_result.active));
        if (got_result.paused !== want_result.paused)
          report_mismatch($sformatf("run_paused %0d want %0d",
                                    got_result.paused, want_result.paused));
        if (got_result.step !== want_result.step)
          report_mismatch($sformatf("step_now %0d want %0d",
                                    got_result.step, want_result.step));
        if (got_result.set_target !== want_result.set_target)
          report_mismatch($sformatf("set_target %0d want %0d",
                                    got_result.set_target, want_result.set_target));
        if (got_result.target !== want_result.target)
          report_mismatch($sformatf("target_temp %0d want %0d",
                                    got_result.target, want_result.target));
        if (got_result.pid !== want_result.pid)
          report_mismatch($sformatf("pid_cmd %0d want %0d",
                                    got_result.pid, want_result.pid));
        if (got_result.off !== want_result.off)
          report_mismatch($sformatf("outputs_off %0d want %0d",
                                    got_result.off, want_result.off));
        if (got_result.cause !== want_result.cause)
          report_mismatch($sformatf("abort_cause %0d want %0d",
                                    got_result.cause, want_result.cause));
        if (got_result.remaining !== want_result.remaining)
          report_mismatch($sformatf("remaining_ms %0d want %0d",
                                    got_result.remaining, want_result.remaining));
      end
    end
  end

  initial begin
    logic [31:0] base;
    logic [31:0] s0;
    logic [4:0]  len;
    int          pick;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FN_LOAD;
    in_now_ms = '0;
    in_panic = 1'b0;
    in_failsafe = 1'b0;
    in_step_index = '0;
    in_step_time = '0;
    in_step_target = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. With no profile loaded everything but stop, load and a
    // safety tick is refused or ignored; results up to the first run are typed in by hand.
    base = 32'hFFFF_FF00;     // the run below wraps the millisecond clock
    s0 = 32'h1234_5678;
    plan.push_back(mk(-1, FN_TICK, 32'd0, 0, 0, 4'd0, 32'd0, 16'sd0, 1,
                      idle_result(ST_IGNORED, PID_NONE)));
    plan.push_back(mk(-1, FN_START, 32'd5, 0, 0, 4'd0, 32'd0, 16'sd0, 1,
                      idle_result(ST_REJECT, PID_NONE)));
    plan.push_back(mk(-1, FN_PAUSE, 32'd6, 0, 0, 4'd0, 32'd0, 16'sd0, 1,
                      idle_result(ST_IGNORED, PID_NONE)));
    plan.push_back(mk(-1, FN_RESUME, 32'd7, 0, 0, 4'd0, 32'd0, 16'sd0, 1,
                      idle_result(ST_IGNORED, PID_NONE)));
    plan.push_back(mk(-1, FN_SPARE6, 32'd8, 0, 0, 4'd0, 32'd0, 16'sd0, 1,
                      idle_result(ST_IGNORED, PID_NONE)));
    plan.push_back(mk(-1, FN_SPARE7, 32'hFFFF_FFFF, 1, 1, 4'd15, 32'hFFFF_FFFF,
                      16'sd32767, 1, idle_result(ST_IGNORED, PID_NONE)));
    // Safety on a tick with no run: done, but nothing to abort.
    plan.push_back(mk(-1, FN_TICK, 32'd9, 1, 1, 4'd0, 32'd0, 16'sd0, 1,
                      idle_result(ST_DONE, PID_NONE)));
    plan.push_back(mk(-1, FN_STOP, 32'd10, 0, 0, 4'd0, 32'd0, 16'sd0, 1,
                      idle_result(ST_DONE, PID_STOP)));
    plan.push_back(mk(-1, FN_LOAD, 32'd11, 0, 0, 4'd15, 32'hFFFF_FFFF, 16'sh8000, 1,
                      idle_result(ST_DONE, PID_NONE)));
    plan.push_back(mk(-1, FN_LOAD, 32'd12, 0, 0, 4'd0, 32'd0, 16'sd3700, 1,
                      idle_result(ST_DONE, PID_NONE)));
    plan.push_back(mk(-1, FN_LOAD, 32'd13, 0, 0, 4'd1, 32'd1000, -16'sd500, 1,
                      idle_result(ST_DONE, PID_NONE)));
    plan.push_back(mk(-1, FN_LOAD, 32'd14, 0, 0, 4'd2, 32'd2500, 16'sd32767, 1,
                      idle_result(ST_DONE, PID_NONE)));
    // Three steps in use until the profile is dropped below.
    plan.push_back(mk(3, FN_START, 32'd15, 0, 1, 4'd0, 32'd0, 16'sd0, 1,
                      idle_result(ST_BLOCKED, PID_NONE)));
    plan.push_back(mk(-1, FN_START, base, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_LOAD, base + 10, 0, 0, 4'd1, 32'd7, 16'sd7, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_TICK, base + 1000, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_PAUSE, base + 1200, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_TICK, base + 1500, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_RESUME, base + 1600, 1, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_RESUME, base + 2200, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    // Enters the last step and finishes the run on the same tick.
    plan.push_back(mk(-1, FN_TICK, base + 3501, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_START, s0, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_START, s0 + 5, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_TICK, s0 + 6, 1, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_START, s0 + 7, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_TICK, s0 + 8, 0, 1, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    plan.push_back(mk(-1, FN_START, s0 + 9, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    // Profile dropped to nothing mid-run: the next tick ends the run.
    plan.push_back(mk(0, FN_TICK, s0 + 10, 0, 0, 4'd0, 32'd0, 16'sd0, 0, NO_RESULT));
    foreach (plan[i]) begin
      if (plan[i].cfg_len >= 0) set_profile_length(5'(plan[i].cfg_len));
      drive_event(plan[i]);
    end

    // Give every table entry a value before any run can read it.
    set_profile_length(5'(STEPS));
    send_event(FN_STOP, $urandom, 0, 0, 4'($urandom), $urandom, 16'($urandom));
    for (int i = 0; i < STEPS; i++)
      send_event(FN_LOAD, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 4'(i), $urandom, 16'($urandom));

    // Random part, phase by phase. Between phases the profile length is
    // usually rewritten with the block drained, sometimes while a run is
    // still live. Near the end both sides stop idling.
    while (event_count < EVENT_GOAL) begin
      idling_on = ($urandom_range(0, 3) != 0) && (event_count < CALM_AFTER);
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) len = 5'd0;
        else if (pick == 1) len = 5'(STEPS);
        else if (pick == 2) len = 5'd1;
        else if (pick == 3) len = 5'($urandom_range(STEPS + 1, 31));
        else len = 5'($urandom_range(2, STEPS - 1));
        set_profile_length(len);
      end
      if ($urandom_range(0, 3) != 0) run_profile_phase();
      else run_noise_phase();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
